>>> design/almd_pkg.sv
// Shared widths and constants for the dBFS level meter.
`timescale 1ns / 1ps
package almd_pkg;
   localparam int SAMPLE_W   = 16;
   localparam int LEVEL_W    = 12;
   localparam int COUNT_W    = 17;
   localparam int ENERGY_W   = 47;
   localparam int POS_W      = 6;
   localparam int FRAC_W     = 16;
   localparam int MANT_W     = 31;
   localparam int LOG_W      = POS_W + FRAC_W;
   localparam int DIFF_W     = 24;
   localparam int MUL_W      = 32;
   localparam int PROD_W     = 2 * MUL_W;

   localparam logic [COUNT_W-1:0]  MAX_SAMPLES = 17'd65536;
   localparam logic signed [LEVEL_W-1:0] LEVEL_FLOOR = -12'sd1920;
   localparam logic signed [MUL_W-1:0]   K_RMS  = 32'sd3156528;
   localparam logic signed [MUL_W-1:0]   K_PEAK = 32'sd6313057;
   localparam logic signed [DIFF_W-1:0]  RMS_OFFSET  = 24'sd1966080;  // 30 << 16
   localparam logic signed [DIFF_W-1:0]  PEAK_OFFSET = 24'sd983040;   // 15 << 16
   localparam logic [SAMPLE_W-1:0] CLIP_POS = 16'h7FFF;
   localparam logic [SAMPLE_W-1:0] CLIP_NEG = 16'h8000;
endpackage

>>> design/audio_level_meter_dbfs.sv
// RMS and peak level meter with dBFS outputs in 1/16 dB steps.
// Samples accumulate one per cycle while idle; input stalls until the report is loaded.
// On block close, three log2 evaluations (energy, count, peak) share one 32x32
// multiplier: each normalises by shifting, then runs 16 squarings and a log step.
// RMS and peak then each take a multiply and a round step. An all-zero block skips
// to the report. Reset clears control state, accumulators and the output valid.
`timescale 1ns / 1ps
module audio_level_meter_dbfs (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [almd_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                 req_last,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [almd_pkg::LEVEL_W-1:0]  rsp_rms_level,
   output logic signed [almd_pkg::LEVEL_W-1:0]  rsp_peak_level,
   output logic [almd_pkg::COUNT_W-1:0]         rsp_clipped_count
);
   import almd_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_NORM = 3'd1;
   localparam logic [2:0] S_SQR  = 3'd2;
   localparam logic [2:0] S_LOG  = 3'd3;
   localparam logic [2:0] S_MUL  = 3'd4;
   localparam logic [2:0] S_RND  = 3'd5;
   localparam logic [2:0] S_DONE = 3'd6;

   localparam logic [1:0] OP_ENERGY = 2'd0;
   localparam logic [1:0] OP_COUNT  = 2'd1;
   localparam logic [1:0] OP_PEAK   = 2'd2;

   logic [2:0]                 state_ff, state_in;
   logic [1:0]                 op_ff, op_in;
   logic [ENERGY_W-1:0]        energy_ff, energy_in;
   logic [COUNT_W-1:0]         total_ff, total_in;
   logic [SAMPLE_W-1:0]        peak_ff, peak_in;
   logic [COUNT_W-1:0]         clip_ff, clip_in;
   // working copies of a closed block
   logic [COUNT_W-1:0]         wtotal_ff, wtotal_in;
   logic [SAMPLE_W-1:0]        wpeak_ff, wpeak_in;
   logic [COUNT_W-1:0]         wclip_ff, wclip_in;
   logic [ENERGY_W-1:0]        norm_ff, norm_in;
   logic [POS_W-1:0]           pos_ff, pos_in;
   logic [MANT_W-1:0]          mant_ff, mant_in;
   logic [FRAC_W-1:0]          frac_ff, frac_in;
   logic [3:0]                 iter_ff, iter_in;
   logic signed [DIFF_W-1:0]   diff_ff, diff_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [LEVEL_W-1:0]  rms_ff, rms_in;
   logic signed [LEVEL_W-1:0]  pk_ff, pk_in;
   logic                       ovalid_ff, ovalid_in;
   logic signed [LEVEL_W-1:0]  orms_ff, orms_in;
   logic signed [LEVEL_W-1:0]  opeak_ff, opeak_in;
   logic [COUNT_W-1:0]         oclip_ff, oclip_in;

   logic                       take;
   logic [SAMPLE_W:0]          mag_wide;
   logic [SAMPLE_W-1:0]        mag;
   logic [2*SAMPLE_W-1:0]      square;
   logic [ENERGY_W-1:0]        energy_new;
   logic [COUNT_W-1:0]         total_new;
   logic [SAMPLE_W-1:0]        peak_new;
   logic [COUNT_W-1:0]         clip_new;
   logic                       close;
   logic signed [MUL_W-1:0]    mul_a, mul_b;
   logic signed [PROD_W-1:0]   mul_p;
   logic [MUL_W-1:0]           sq;
   logic signed [DIFF_W-1:0]   logv;
   logic signed [PROD_W-1:0]   rnd_sum;
   logic signed [MUL_W-1:0]    q;
   logic signed [LEVEL_W-1:0]  level;

   assign req_stall         = (state_ff != S_IDLE);
   assign take              = req_valid && !req_stall;
   assign rsp_valid         = ovalid_ff;
   assign rsp_rms_level     = orms_ff;
   assign rsp_peak_level    = opeak_ff;
   assign rsp_clipped_count = oclip_ff;

   assign mag_wide   = req_sample[SAMPLE_W-1] ? -{req_sample[SAMPLE_W-1], req_sample}
                                              : {1'b0, req_sample};
   assign mag        = mag_wide[SAMPLE_W-1:0];
   assign square     = mag * mag;
   assign energy_new = energy_ff + ENERGY_W'(square);
   assign total_new  = total_ff + COUNT_W'(1);
   assign peak_new   = (mag > peak_ff) ? mag : peak_ff;
   assign clip_new   = ((req_sample == CLIP_POS) || (req_sample == CLIP_NEG))
                       ? clip_ff + COUNT_W'(1) : clip_ff;
   assign close      = req_last || (total_new == MAX_SAMPLES);

   // shared multiplier: squaring of the mantissa, or scaling of a log difference
   always_comb begin
      if (state_ff == S_SQR) begin
         mul_a = MUL_W'({1'b0, mant_ff});
         mul_b = MUL_W'({1'b0, mant_ff});
      end else begin
         mul_a = MUL_W'(diff_ff);
         mul_b = (op_ff == OP_PEAK) ? K_PEAK : K_RMS;
      end
   end
   assign mul_p = mul_a * mul_b;
   assign sq    = mul_p[30 +: MUL_W];

   assign logv    = DIFF_W'(signed'({1'b0, pos_ff, frac_ff}));
   assign rnd_sum = prod_ff + (PROD_W'(1) <<< 31);
   assign q       = rnd_sum[PROD_W-1 -: MUL_W];
   always_comb begin
      if (q < MUL_W'(LEVEL_FLOOR))
         level = LEVEL_FLOOR;
      else if (q > 0)
         level = '0;
      else
         level = q[LEVEL_W-1:0];
   end

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      energy_in = energy_ff;
      total_in  = total_ff;
      peak_in   = peak_ff;
      clip_in   = clip_ff;
      wtotal_in = wtotal_ff;
      wpeak_in  = wpeak_ff;
      wclip_in  = wclip_ff;
      norm_in   = norm_ff;
      pos_in    = pos_ff;
      mant_in   = mant_ff;
      frac_in   = frac_ff;
      iter_in   = iter_ff;
      diff_in   = diff_ff;
      prod_in   = prod_ff;
      rms_in    = rms_ff;
      pk_in     = pk_ff;
      ovalid_in = ovalid_ff;
      orms_in   = orms_ff;
      opeak_in  = opeak_ff;
      oclip_in  = oclip_ff;

      if (ovalid_ff && !rsp_stall)
         ovalid_in = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (take) begin
               if (close) begin
                  energy_in = '0;
                  total_in  = '0;
                  peak_in   = '0;
                  clip_in   = '0;
                  wtotal_in = total_new;
                  wpeak_in  = peak_new;
                  wclip_in  = clip_new;
                  op_in     = OP_ENERGY;
                  norm_in   = energy_new;
                  pos_in    = POS_W'(ENERGY_W - 1);
                  if (energy_new == '0) begin
                     // all-zero block: energy and peak are both zero
                     rms_in   = LEVEL_FLOOR;
                     pk_in    = LEVEL_FLOOR;
                     state_in = S_DONE;
                  end else begin
                     state_in = S_NORM;
                  end
               end else begin
                  energy_in = energy_new;
                  total_in  = total_new;
                  peak_in   = peak_new;
                  clip_in   = clip_new;
               end
            end
         end
         S_NORM: begin
            if (norm_ff[ENERGY_W-1]) begin
               mant_in  = norm_ff[ENERGY_W-1 -: MANT_W];
               frac_in  = '0;
               iter_in  = '0;
               state_in = S_SQR;
            end else begin
               norm_in = norm_ff << 1;
               pos_in  = pos_ff - POS_W'(1);
            end
         end
         S_SQR: begin
            frac_in = {frac_ff[FRAC_W-2:0], sq[MUL_W-1]};
            mant_in = sq[MUL_W-1] ? sq[MUL_W-1:1] : sq[MANT_W-1:0];
            iter_in = iter_ff + 4'd1;
            if (iter_ff == 4'd15)
               state_in = S_LOG;
         end
         S_LOG: begin
            pos_in = POS_W'(ENERGY_W - 1);
            priority case (op_ff)
               OP_ENERGY: begin
                  diff_in  = logv;
                  op_in    = OP_COUNT;
                  norm_in  = ENERGY_W'(wtotal_ff);
                  state_in = S_NORM;
               end
               OP_COUNT: begin
                  diff_in  = diff_ff - logv - RMS_OFFSET;
                  state_in = S_MUL;
               end
               default: begin
                  diff_in  = logv - PEAK_OFFSET;
                  state_in = S_MUL;
               end
            endcase
         end
         S_MUL: begin
            prod_in  = mul_p;
            state_in = S_RND;
         end
         S_RND: begin
            if (op_ff == OP_PEAK) begin
               pk_in    = level;
               state_in = S_DONE;
            end else begin
               rms_in   = level;
               op_in    = OP_PEAK;
               norm_in  = ENERGY_W'(wpeak_ff);
               pos_in   = POS_W'(ENERGY_W - 1);
               state_in = S_NORM;
            end
         end
         S_DONE: begin
            if (!ovalid_ff || !rsp_stall) begin
               ovalid_in = 1'b1;
               orms_in   = rms_ff;
               opeak_in  = pk_ff;
               oclip_in  = wclip_ff;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         op_ff     <= OP_ENERGY;
         energy_ff <= '0;
         total_ff  <= '0;
         peak_ff   <= '0;
         clip_ff   <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         op_ff     <= op_in;
         energy_ff <= energy_in;
         total_ff  <= total_in;
         peak_ff   <= peak_in;
         clip_ff   <= clip_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      wtotal_ff <= wtotal_in;
      wpeak_ff  <= wpeak_in;
      wclip_ff  <= wclip_in;
      norm_ff   <= norm_in;
      pos_ff    <= pos_in;
      mant_ff   <= mant_in;
      frac_ff   <= frac_in;
      iter_ff   <= iter_in;
      diff_ff   <= diff_in;
      prod_ff   <= prod_in;
      rms_ff    <= rms_in;
      pk_ff     <= pk_in;
      orms_ff   <= orms_in;
      opeak_ff  <= opeak_in;
      oclip_ff  <= oclip_in;
   end
endmodule
